// ----- rtl/pidp_pkg.sv -----
// ----------------------------------------------------------------------------
// pidp_pkg: shared types and constants for the peer identifier parser
// Holds the phase encoding, character constants and the item structs that
// travel on the input and result channels.
// ----------------------------------------------------------------------------
package pidp_pkg;

	// Character codes recognized by the parser.
	localparam logic [7:0] CHAR_I     = 8'h69;
	localparam logic [7:0] CHAR_P     = 8'h70;
	localparam logic [7:0] CHAR_SLASH = 8'h2F;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	// Largest port number that is accepted.
	localparam logic [15:0] PORT_MAX = 16'hFFFF;

	// Parse phase.
	typedef enum logic [2:0] {
		PH_P1     = 3'd0,
		PH_P2     = 3'd1,
		PH_P3     = 3'd2,
		PH_AFIRST = 3'd3,
		PH_AREST  = 3'd4,
		PH_PFIRST = 3'd5,
		PH_PREST  = 3'd6
	} phase_t;

	// Parser state carried from one character to the next.
	typedef struct packed {
		phase_t      phase;
		logic        failed;
		logic [15:0] port_accum;
	} parse_state_t;

	// One input item: a character and its end-of-identifier mark.
	typedef struct packed {
		logic [7:0] char_in;
		logic       is_last;
	} char_item_t;

	// One result item.
	typedef struct packed {
		logic        address_valid;
		logic [7:0]  address_char;
		logic        finished;
		logic        accepted;
		logic [15:0] port_value;
	} result_item_t;

endpackage

// ----- rtl/pidp_stream_if.sv -----
// ----------------------------------------------------------------------------
// pidp_stream_if: valid/ready channel
// Carries one item of the given payload type per handshake.
// ----------------------------------------------------------------------------
interface pidp_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/pidp_step.sv -----
// ----------------------------------------------------------------------------
// pidp_step: one parse step
// Given the current parser state and one character, computes the next state
// and the result item for that character.
// ----------------------------------------------------------------------------
module pidp_step
	import pidp_pkg::*;
(
	input  parse_state_t state,
	input  logic [7:0]   char_in,
	input  logic         is_last,
	output parse_state_t next_state,
	output result_item_t result
);

	logic        is_digit;
	logic [3:0]  digit;
	logic [19:0] port_next;
	logic        addr_ok;
	logic        acc;
	parse_state_t upd;

	// Digit decode and the times-ten accumulate as two shifts and two adds.
	assign is_digit  = (char_in >= CHAR_ZERO) && (char_in <= CHAR_NINE);
	assign digit     = 4'(char_in - CHAR_ZERO);
	assign port_next = ({4'd0, state.port_accum} << 3) + ({4'd0, state.port_accum} << 1)
		+ {16'd0, digit};

	// Phase transitions; errors latch the failed flag and freeze the phase.
	always_comb begin
		upd     = state;
		addr_ok = 1'b0;
		if (!state.failed) begin
			unique case (state.phase)
				PH_P1: begin
					if (char_in == CHAR_I) upd.phase = PH_P2;
					else upd.failed = 1'b1;
				end
				PH_P2: begin
					if (char_in == CHAR_P) upd.phase = PH_P3;
					else upd.failed = 1'b1;
				end
				PH_P3: begin
					if (char_in == CHAR_SLASH) upd.phase = PH_AFIRST;
					else upd.failed = 1'b1;
				end
				PH_AFIRST: begin
					if (char_in == CHAR_SLASH) begin
						upd.failed = 1'b1;
					end else begin
						addr_ok   = 1'b1;
						upd.phase = PH_AREST;
					end
				end
				PH_AREST: begin
					if (char_in == CHAR_SLASH) upd.phase = PH_PFIRST;
					else addr_ok = 1'b1;
				end
				PH_PFIRST: begin
					if (is_digit) begin
						upd.port_accum = {12'd0, digit};
						upd.phase      = PH_PREST;
					end else begin
						upd.failed = 1'b1;
					end
				end
				PH_PREST: begin
					if (is_digit && (port_next <= {4'd0, PORT_MAX}))
						upd.port_accum = port_next[15:0];
					else
						upd.failed = 1'b1;
				end
				default: upd.failed = 1'b1;
			endcase
		end
	end

	// Verdict on the last character, which also returns the parser to start.
	assign acc = is_last && !upd.failed && (upd.phase == PH_PREST);

	always_comb begin
		result.address_valid = addr_ok;
		result.address_char  = addr_ok ? char_in : 8'd0;
		result.finished      = is_last;
		result.accepted      = acc;
		result.port_value    = acc ? upd.port_accum : 16'd0;
		if (is_last) begin
			next_state.phase      = PH_P1;
			next_state.failed     = 1'b0;
			next_state.port_accum = 16'd0;
		end else begin
			next_state = upd;
		end
	end

endmodule

// ----- rtl/peer_id_string_parser_top.sv -----
// ----------------------------------------------------------------------------
// peer_id_string_parser_top: peer identifier parser
// Checks character streams of the form "ip/<address>/<port>", passes the
// address characters out and reports the verdict and port on the last one.
//
//   Channel   Dir  Payload                                          Per item
//   chars     in   char_in[7:0], is_last                            1 char
//   results   out  address_valid, address_char[7:0], finished,      1 result
//                  accepted, port_value[15:0]
//
// An item is registered at the input, parsed by the step logic and held in the
// result register; one item per cycle is sustained while results.ready stays high.
// The parser state register closes the only loop, one step per cycle while stage 1 advances.
// Reset clears the parser to the start of an identifier and empties both stages.
// A stalled result holds the input stage, which backs up to chars.ready.
// ----------------------------------------------------------------------------
module peer_id_string_parser_top
	import pidp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	pidp_stream_if.sink          chars,
	pidp_stream_if.source        results
);

	logic         valid_s1;
	logic [7:0]   char_s1;
	logic         last_s1;
	parse_state_t state_q;
	parse_state_t state_next;
	result_item_t step_res;
	logic         out_valid_q;
	result_item_t out_q;
	logic         advance;

	// Stage 1 moves on when the result register is empty or being drained.
	assign advance     = valid_s1 && (!out_valid_q || results.ready);
	assign chars.ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			char_s1 <= chars.payload.char_in;
			last_s1 <= chars.payload.is_last;
		end
	end

	// Parse step.
	pidp_step u_step (
		.state      (state_q),
		.char_in    (char_s1),
		.is_last    (last_s1),
		.next_state (state_next),
		.result     (step_res)
	);

	// Parser state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase      <= PH_P1;
			state_q.failed     <= 1'b0;
			state_q.port_accum <= 16'd0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= step_res;
		end
	end

	assign results.valid   = out_valid_q;
	assign results.payload = out_q;

	// The last character always returns the parser to its start state.
	a_last_resets: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> state_q.phase == PH_P1 && !state_q.failed
			&& state_q.port_accum == 16'd0)
		else $error("parser state not cleared after last character");

	// Once an error is seen, no address characters are passed out.
	a_no_addr_after_fail: assert property (@(posedge clk) disable iff (!arst_n)
		advance && state_q.failed |-> !step_res.address_valid && !step_res.accepted)
		else $error("output after error in identifier");

	// A held input stage keeps its character until it advances.
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(char_s1) && $stable(last_s1))
		else $error("input stage changed while stalled");

	// A verdict appears only on the result for the last character.
	a_accept_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.accepted |-> out_q.finished && !out_q.address_valid)
		else $error("accepted result not marked finished");

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the peer identifier parser
// Feeds character items that form identifiers of the shape "ip/<addr>/<port>",
// well formed, damaged and pure noise, and predicts each result item with a
// behavioral copy of the parser. Results are checked field by field in order.
// The sender idles in random bursts, the receiver stalls on its own pattern,
// and one long receiver hold-off makes the block back up to its input.
// ----------------------------------------------------------------------------
module tb_top;
	import pidp_pkg::*;

	localparam int unsigned ITEM_TARGET     = 1200;
	localparam int unsigned HOLD_OFF_CYCLES = 300;
	localparam int unsigned DRAIN_CYCLES    = 8;
	localparam int unsigned CYCLE_LIMIT     = 200000;

	typedef logic [7:0] char_q_t[$];

	// Ways a well-formed identifier gets damaged.
	typedef enum int unsigned {
		MUT_REPLACE,
		MUT_TRUNCATE,
		MUT_INSERT
	} mutation_t;

	// Receiver stall patterns.
	typedef enum int unsigned {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_PERIODIC
	} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n;

	pidp_stream_if #(.payload_t(char_item_t))   chars_if ();
	pidp_stream_if #(.payload_t(result_item_t)) results_if ();

	peer_id_string_parser_top i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (chars_if),
		.results (results_if)
	);

	// Shadow parser state.
	phase_t      pr_phase  = PH_P1;
	logic        pr_failed = 1'b0;
	logic [15:0] pr_port   = '0;

	result_item_t verdict_q[$];

	int unsigned error_count    = 0;
	int unsigned items_sent     = 0;
	int unsigned ids_finished   = 0;
	int unsigned ids_accepted   = 0;
	int unsigned addr_chars_out = 0;
	int unsigned cycle_count    = 0;
	int unsigned hold_off_left  = 0;
	int unsigned burst_left     = 0;
	bit          gaps_enabled   = 1'b1;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Advance the shadow parser by one character and return the result it gives.
	function automatic result_item_t peer_id_step(input char_item_t it);
		result_item_t r;
		logic [7:0]   c;
		logic         digit;
		int unsigned  v;
		c = it.char_in;
		digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
		r = '0;
		if (!pr_failed) begin
			case (pr_phase)
				PH_P1: begin
					if (c == CHAR_I) pr_phase = PH_P2;
					else pr_failed = 1'b1;
				end
				PH_P2: begin
					if (c == CHAR_P) pr_phase = PH_P3;
					else pr_failed = 1'b1;
				end
				PH_P3: begin
					if (c == CHAR_SLASH) pr_phase = PH_AFIRST;
					else pr_failed = 1'b1;
				end
				PH_AFIRST: begin
					if (c == CHAR_SLASH) begin
						pr_failed = 1'b1;
					end else begin
						r.address_valid = 1'b1;
						pr_phase = PH_AREST;
					end
				end
				PH_AREST: begin
					if (c == CHAR_SLASH) pr_phase = PH_PFIRST;
					else r.address_valid = 1'b1;
				end
				PH_PFIRST: begin
					if (digit) begin
						pr_port = 16'(c - CHAR_ZERO);
						pr_phase = PH_PREST;
					end else begin
						pr_failed = 1'b1;
					end
				end
				PH_PREST: begin
					if (digit) begin
						v = 32'(pr_port) * 10 + 32'(c - CHAR_ZERO);
						if (v > 32'(PORT_MAX)) pr_failed = 1'b1;
						else pr_port = v[15:0];
					end else begin
						pr_failed = 1'b1;
					end
				end
				default: begin
					pr_failed = 1'b1;
				end
			endcase
		end
		if (r.address_valid) r.address_char = c;
		// The last character closes the identifier and rearms the parser.
		if (it.is_last) begin
			r.finished = 1'b1;
			r.accepted = !pr_failed && (pr_phase == PH_PREST);
			if (r.accepted) r.port_value = pr_port;
			pr_phase = PH_P1;
			pr_failed = 1'b0;
			pr_port = '0;
		end
		return r;
	endfunction

	task automatic check_field(input string field, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, actual %0d", field, want, got);
			error_count++;
		end
	endtask

	// Predict on every accepted character, then check every accepted result.
	always @(posedge clk) begin
		result_item_t want;
		result_item_t got;
		if (arst_n) begin
			if (chars_if.valid && chars_if.ready)
				verdict_q.push_back(peer_id_step(chars_if.payload));
			if (results_if.valid && results_if.ready) begin
				got = results_if.payload;
				if (verdict_q.size() == 0) begin
					$error("result item arrived with nothing outstanding");
					error_count++;
				end else begin
					want = verdict_q.pop_front();
					check_field("address_valid", 16'(want.address_valid), 16'(got.address_valid));
					check_field("address_char", 16'(want.address_char), 16'(got.address_char));
					check_field("finished", 16'(want.finished), 16'(got.finished));
					check_field("accepted", 16'(want.accepted), 16'(got.accepted));
					check_field("port_value", want.port_value, got.port_value);
				end
				if (got.finished === 1'b1) ids_finished++;
				if (got.finished === 1'b1 && got.accepted === 1'b1) ids_accepted++;
				if (got.address_valid === 1'b1) addr_chars_out++;
			end
		end
	end

	// Receiver: random stall patterns, overridden by a counted hold-off.
	initial begin
		rx_mode_t    mode;
		int unsigned mode_left;
		mode = RX_OPEN;
		mode_left = 0;
		results_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_left != 0) begin
				hold_off_left--;
				results_if.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(8, 80);
				end
				mode_left--;
				case (mode)
					RX_OPEN:     results_if.ready <= 1'b1;
					RX_COIN:     results_if.ready <= 1'($urandom_range(0, 1));
					RX_SPARSE:   results_if.ready <= ($urandom_range(0, 3) == 0);
					RX_PERIODIC: results_if.ready <= (mode_left % 3 == 0);
					default:     results_if.ready <= 1'b1;
				endcase
			end
		end
	end

	// Run limit.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$error("run timed out with %0d result items outstanding", verdict_q.size());
		$display("FAIL");
		$finish;
	end

	// Offer one character item and wait until it is taken.
	task automatic send_char(input logic [7:0] c, input logic last);
		char_item_t it;
		it.char_in = c;
		it.is_last = last;
		@(negedge clk);
		if (gaps_enabled) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 12);
				chars_if.valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
			end
			burst_left--;
		end
		chars_if.valid <= 1'b1;
		chars_if.payload <= it;
		do @(posedge clk); while (chars_if.ready !== 1'b1);
		items_sent++;
	endtask

	task automatic send_peer_id(input char_q_t s);
		for (int k = 0; k < s.size(); k++)
			send_char(s[k], k == s.size() - 1);
	endtask

	task automatic append_digits(ref char_q_t s, input int unsigned value,
			input int unsigned zeros);
		string t;
		t = $sformatf("%0d", value);
		repeat (zeros) s.push_back(CHAR_ZERO);
		for (int k = 0; k < t.len(); k++)
			s.push_back(t[k]);
	endtask

	// Mostly well-formed identifiers with random content; some damaged, some noise.
	task automatic make_peer_id(output char_q_t s);
		int unsigned shape;
		int unsigned addr_len;
		int unsigned port_val;
		int unsigned pos;
		logic [7:0]  ch;
		s = {};
		shape = $urandom_range(0, 99);
		if (shape < 12) begin
			repeat ($urandom_range(1, 8)) begin
				ch = 8'($urandom_range(0, 255));
				if ($urandom_range(0, 3) == 0)
					ch = ($urandom_range(0, 1) != 0) ? CHAR_I : CHAR_SLASH;
				s.push_back(ch);
			end
		end else begin
			s = {CHAR_I, CHAR_P, CHAR_SLASH};
			addr_len = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 20)
				: $urandom_range(1, 4);
			repeat (addr_len) begin
				do ch = 8'($urandom_range(0, 255)); while (ch == CHAR_SLASH);
				s.push_back(ch);
			end
			s.push_back(CHAR_SLASH);
			pos = $urandom_range(0, 3);
			if (pos == 0) port_val = $urandom_range(0, 9);
			else if (pos == 1) port_val = $urandom_range(0, 65535);
			else if (pos == 2) port_val = $urandom_range(65525, 65545);
			else port_val = $urandom_range(0, 999999);
			append_digits(s, port_val,
				($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0);
			if (shape >= 75) begin
				pos = $urandom_range(0, s.size() - 1);
				ch = ($urandom_range(0, 2) == 0) ? CHAR_SLASH : 8'($urandom_range(0, 255));
				case (mutation_t'($urandom_range(0, 2)))
					MUT_REPLACE:  s[pos] = ch;
					MUT_TRUNCATE: s = s[0:pos];
					default:      s.insert(pos, ch);
				endcase
			end
		end
	endtask

	// Stop offering and let every outstanding result come back.
	task automatic wait_until_drained();
		@(negedge clk);
		chars_if.valid <= 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Boundary ports, extreme address bytes and the early-exit cases.
	task automatic test_directed_cases();
		char_q_t s;
		// Largest port with the top byte value as address.
		s = {CHAR_I, CHAR_P, CHAR_SLASH, 8'hFF, CHAR_SLASH};
		append_digits(s, 65535, 0);
		send_peer_id(s);
		// One past the largest port, zero byte as address.
		s = {CHAR_I, CHAR_P, CHAR_SLASH, 8'h00, CHAR_SLASH};
		append_digits(s, 65536, 0);
		send_peer_id(s);
		// Address that starts with a slash.
		s = {CHAR_I, CHAR_P, CHAR_SLASH, CHAR_SLASH};
		send_peer_id(s);
		// Identifier that ends inside the address.
		s = {CHAR_I, CHAR_P, CHAR_SLASH, CHAR_P};
		send_peer_id(s);
		wait_until_drained();
	endtask

	// The receiver holds off while the sender keeps offering without gaps.
	task automatic test_result_backpressure();
		char_q_t s;
		gaps_enabled = 1'b0;
		hold_off_left = HOLD_OFF_CYCLES;
		repeat (8) begin
			make_peer_id(s);
			send_peer_id(s);
		end
		gaps_enabled = 1'b1;
		wait_until_drained();
	endtask

	task automatic test_random_identifiers();
		char_q_t     s;
		int unsigned ids;
		ids = 0;
		while (items_sent < ITEM_TARGET) begin
			// Switch between bursty and gap-free sending now and then.
			if (ids % 16 == 0) gaps_enabled = ($urandom_range(0, 3) != 0);
			make_peer_id(s);
			send_peer_id(s);
			ids++;
		end
		wait_until_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		chars_if.valid = 1'b0;
		chars_if.payload = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		test_directed_cases();
		test_result_backpressure();
		test_random_identifiers();

		$display("Sent %0d characters; %0d identifiers closed, %0d of them accepted.",
			items_sent, ids_finished, ids_accepted);
		$display("%0d address characters came out; %0d field errors seen.",
			addr_chars_out, error_count);
		if (error_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/pidp_pkg.sv
rtl/pidp_stream_if.sv
rtl/pidp_step.sv
rtl/peer_id_string_parser_top.sv
tb/sv/tb_top.sv
